// ===== hw/rtl/jlvs_pkg.sv =====
// Shared types, codes and fixed-point constants of the velocity shaper.
`default_nettype none
package jlvs_pkg;

  // Packed widths of the stream words.
  localparam int IN_W  = 312;
  localparam int OUT_W = 136;

  localparam int TICKS_W = 18;
  localparam logic [TICKS_W-1:0] TICKS_MAX    = 18'd262143;
  localparam logic [TICKS_W-1:0] MOTION_TICKS = 18'd150000;

  // Yaw unwrap constants in Q16.16.
  localparam logic signed [31:0] YAW_TOTAL_RESET  = 32'sd205887;
  localparam logic signed [18:0] YAW_BEFORE_RESET = 19'sd205887;
  localparam logic [19:0]        WRAP_JUMP        = 20'd196608;
  localparam logic signed [20:0] TWO_PI_Q         = 21'sd411775;

  // Configuration register indexes and reset values.
  localparam logic [2:0] CFG_TICK_PERIOD    = 3'd0;
  localparam logic [2:0] CFG_TICK_RATE      = 3'd1;
  localparam logic [2:0] CFG_LIN_VEL_LIMIT  = 3'd2;
  localparam logic [2:0] CFG_LIN_ACC_LIMIT  = 3'd3;
  localparam logic [2:0] CFG_LIN_JERK_LIMIT = 3'd4;
  localparam logic [2:0] CFG_ANG_VEL_LIMIT  = 3'd5;
  localparam logic [2:0] CFG_ANG_ACC_LIMIT  = 3'd6;
  localparam logic [2:0] CFG_ANG_JERK_LIMIT = 3'd7;

  localparam logic [23:0] TICK_PERIOD_RESET    = 24'd16777;
  localparam logic [15:0] TICK_RATE_RESET      = 16'd1000;
  localparam logic [30:0] LIN_VEL_LIMIT_RESET  = 31'd111411;
  localparam logic [30:0] LIN_ACC_LIMIT_RESET  = 31'd85197;
  localparam logic [30:0] LIN_JERK_LIMIT_RESET = 31'd42598400;
  localparam logic [30:0] ANG_VEL_LIMIT_RESET  = 31'd163840;
  localparam logic [30:0] ANG_ACC_LIMIT_RESET  = 31'd163840;
  localparam logic [30:0] ANG_JERK_LIMIT_RESET = 31'd81920000;

  // Datapath operations.
  localparam logic [3:0] OP_IDLE  = 4'd0;
  localparam logic [3:0] OP_LOAD  = 4'd1;
  localparam logic [3:0] OP_YAW1  = 4'd2;
  localparam logic [3:0] OP_YAW2  = 4'd3;
  localparam logic [3:0] OP_YERR  = 4'd4;
  localparam logic [3:0] OP_DIFF  = 4'd5;
  localparam logic [3:0] OP_MRATE = 4'd6;
  localparam logic [3:0] OP_MSTEP = 4'd7;
  localparam logic [3:0] OP_STEP  = 4'd8;
  localparam logic [3:0] OP_RAMP  = 4'd9;
  localparam logic [3:0] OP_MDT   = 4'd10;
  localparam logic [3:0] OP_ROUND = 4'd11;
  localparam logic [3:0] OP_ACC   = 4'd12;
  localparam logic [3:0] OP_OUT   = 4'd13;

  // Axis codes.
  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_W = 2'd2;

  typedef struct packed {
    logic [3:0] op;
    logic [1:0] axis;
  } jlvs_cmd_t;

endpackage
`default_nettype wire

// ===== hw/rtl/jerk_limited_velocity_shaper_core.sv =====
// An accepted input word goes through the yaw unwrap steps (YAW1, YAW2, YERR) and
// then DIFF to ACC for each axis; the single shared multiplier runs three products
// for each of the x, y and yaw axes in turn. Only one word is worked on at a time.
// A new input word is taken while the previous output word still waits.
// Reset (rst, synchronous) restores all configuration registers to their
// defaults, yaw state to pi, the tick count to zero and empties the output.
`default_nettype none
module jerk_limited_velocity_shaper_core import jlvs_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_write,
  input  wire logic [2:0]        cfg_addr,
  input  wire logic [30:0]       cfg_data,
  input  wire logic              s_tvalid,
  output logic                   s_tready,
  // want_vx, want_vy, want_yaw, meas_yaw[18:0], meas_vx, meas_vy, meas_wz,
  // meas_ax, meas_ay, meas_awz, zero fill
  input  wire logic [IN_W-1:0]   s_tdata,
  output logic                   m_tvalid,
  input  wire logic              m_tready,
  // out_vx, out_vy, out_wz, unwrapped_yaw, motion_done, zero fill
  output logic [OUT_W-1:0]       m_tdata
);

  jlvs_cmd_t cmd;

  jlvs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd)
  );

  jlvs_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_addr  (cfg_addr),
    .cfg_data  (cfg_data),
    .in_data   (s_tdata),
    .cmd       (cmd),
    .out_data  (m_tdata)
  );

`ifndef SYNTHESIS
  // Only one word is worked on at a time.
  assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input taken while a word is in progress");

  // Input is latched only on a real handshake.
  assert property (@(posedge clk) disable iff (rst)
    (cmd.op == OP_LOAD) |-> (s_tvalid && s_tready))
    else $error("input latched without handshake");

  // Loading the output register always presents a word.
  assert property (@(posedge clk) disable iff (rst)
    (cmd.op == OP_OUT) |=> m_tvalid)
    else $error("output word lost");

  // A pending output word is never overwritten.
  assert property (@(posedge clk) disable iff (rst)
    (cmd.op == OP_OUT) |-> (!m_tvalid || m_tready))
    else $error("output register overwritten");
`endif

endmodule
`default_nettype wire

// ===== hw/rtl/jlvs_ctrl.sv =====
// Sequencer that steps the datapath through the yaw unwrap and the three axes.
`default_nettype none
module jlvs_ctrl import jlvs_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      s_tvalid,
  output logic           s_tready,
  output logic           m_tvalid,
  input  wire logic      m_tready,
  output jlvs_cmd_t      cmd
);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_YAW1  = 4'd1;
  localparam logic [3:0] ST_YAW2  = 4'd2;
  localparam logic [3:0] ST_YERR  = 4'd3;
  localparam logic [3:0] ST_DIFF  = 4'd4;
  localparam logic [3:0] ST_MRATE = 4'd5;
  localparam logic [3:0] ST_MSTEP = 4'd6;
  localparam logic [3:0] ST_STEP  = 4'd7;
  localparam logic [3:0] ST_RAMP  = 4'd8;
  localparam logic [3:0] ST_MDT   = 4'd9;
  localparam logic [3:0] ST_ROUND = 4'd10;
  localparam logic [3:0] ST_ACC   = 4'd11;
  localparam logic [3:0] ST_OUT   = 4'd12;

  logic [3:0] state, state_next;
  logic [1:0] axis, axis_next;
  logic       out_free;

  assign s_tready = (state == ST_IDLE);
  assign out_free = !m_tvalid || m_tready;

  always_comb begin
    state_next = state;
    axis_next  = axis;
    cmd.axis   = axis;
    cmd.op     = OP_IDLE;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          cmd.op     = OP_LOAD;
          state_next = ST_YAW1;
          axis_next  = AXIS_X;
        end
      end
      ST_YAW1:  begin cmd.op = OP_YAW1;  state_next = ST_YAW2;  end
      ST_YAW2:  begin cmd.op = OP_YAW2;  state_next = ST_YERR;  end
      ST_YERR:  begin cmd.op = OP_YERR;  state_next = ST_DIFF;  end
      ST_DIFF:  begin cmd.op = OP_DIFF;  state_next = ST_MRATE; end
      ST_MRATE: begin cmd.op = OP_MRATE; state_next = ST_MSTEP; end
      ST_MSTEP: begin cmd.op = OP_MSTEP; state_next = ST_STEP;  end
      ST_STEP:  begin cmd.op = OP_STEP;  state_next = ST_RAMP;  end
      ST_RAMP:  begin cmd.op = OP_RAMP;  state_next = ST_MDT;   end
      ST_MDT:   begin cmd.op = OP_MDT;   state_next = ST_ROUND; end
      ST_ROUND: begin cmd.op = OP_ROUND; state_next = ST_ACC;   end
      ST_ACC: begin
        cmd.op = OP_ACC;
        if (axis == AXIS_W) begin
          state_next = ST_OUT;
        end else begin
          axis_next  = axis + 2'd1;
          state_next = ST_DIFF;
        end
      end
      ST_OUT: begin
        // The results wait here until the output register has room.
        if (out_free) begin
          cmd.op     = OP_OUT;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      axis     <= AXIS_X;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      axis  <= axis_next;
      if (cmd.op == OP_OUT) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/jlvs_datapath.sv =====
// Registers, yaw unwrap logic and the shared multiplier of the velocity shaper.
`default_nettype none
module jlvs_datapath import jlvs_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_write,
  input  wire logic [2:0]       cfg_addr,
  input  wire logic [30:0]      cfg_data,
  input  wire logic [IN_W-1:0]  in_data,
  input  wire jlvs_cmd_t        cmd,
  output logic [OUT_W-1:0]      out_data
);

  function automatic logic signed [31:0] sat32(input logic signed [34:0] v);
    logic signed [31:0] r;
    if (v > 35'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -35'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // Configuration.
  logic [23:0] tick_period;
  logic [15:0] tick_rate;
  logic [30:0] lin_vel_limit, lin_acc_limit, lin_jerk_limit;
  logic [30:0] ang_vel_limit, ang_acc_limit, ang_jerk_limit;

  // Tick state.
  logic signed [31:0]  yaw_total;
  logic signed [18:0]  yaw_before;
  logic [TICKS_W-1:0]  elapsed;

  // Latched input word.
  logic signed [31:0] want_vx, want_vy, want_yaw, meas_vx, meas_vy, meas_wz;
  logic signed [31:0] meas_ax, meas_ay, meas_awz;
  logic signed [18:0] meas_yaw;

  // Working registers.
  logic signed [19:0] ydiff;
  logic               wrap_up, wrap_dn;
  logic signed [32:0] want_w;
  logic signed [33:0] d_r;
  logic signed [58:0] prod;
  logic signed [31:0] ta;
  logic [30:0]        step_r;
  logic signed [33:0] diff_r;
  logic               a_neg;
  logic [32:0]        a_mag;
  logic signed [33:0] r_s;
  logic signed [31:0] res_vx, res_vy, res_wz;

  // Axis selection.
  logic signed [33:0] want_sel;
  logic signed [31:0] mv_sel, ma_sel;
  logic [30:0]        vlim_sel, alim_sel, jlim_sel;

  always_comb begin
    case (cmd.axis)
      AXIS_X: begin
        want_sel = {{2{want_vx[31]}}, want_vx};
        mv_sel   = meas_vx;
        ma_sel   = meas_ax;
        vlim_sel = lin_vel_limit;
        alim_sel = lin_acc_limit;
        jlim_sel = lin_jerk_limit;
      end
      AXIS_Y: begin
        want_sel = {{2{want_vy[31]}}, want_vy};
        mv_sel   = meas_vy;
        ma_sel   = meas_ay;
        vlim_sel = lin_vel_limit;
        alim_sel = lin_acc_limit;
        jlim_sel = lin_jerk_limit;
      end
      default: begin
        want_sel = {want_w[32], want_w};
        mv_sel   = meas_wz;
        ma_sel   = meas_awz;
        vlim_sel = ang_vel_limit;
        alim_sel = ang_acc_limit;
        jlim_sel = ang_jerk_limit;
      end
    endcase
  end

  // Velocity clamp and velocity error.
  logic signed [33:0] vlim_s, tv, d_next, mv_ext, ma_ext, ta_ext;

  assign vlim_s = $signed({3'b000, vlim_sel});
  assign mv_ext = {{2{mv_sel[31]}}, mv_sel};
  assign ma_ext = {{2{ma_sel[31]}}, ma_sel};
  assign ta_ext = {{2{ta[31]}}, ta};

  always_comb begin
    if (want_sel > vlim_s) begin
      tv = vlim_s;
    end else if (want_sel < -vlim_s) begin
      tv = -vlim_s;
    end else begin
      tv = want_sel;
    end
  end
  assign d_next = tv - mv_ext;

  // Shared multiplier: velocity error times rate, jerk times period, accel times period.
  logic signed [33:0] mul_a;
  logic signed [24:0] mul_b;
  logic signed [58:0] mul_p;

  always_comb begin
    case (cmd.op)
      OP_MRATE: begin
        mul_a = d_r;
        mul_b = $signed({9'd0, tick_rate});
      end
      OP_MSTEP: begin
        mul_a = $signed({3'b000, jlim_sel});
        mul_b = $signed({1'b0, tick_period});
      end
      default: begin
        mul_a = $signed({1'b0, a_mag});
        mul_b = $signed({1'b0, tick_period});
      end
    endcase
  end
  assign mul_p = mul_a * mul_b;

  // Acceleration clamp on the rate product.
  logic signed [58:0] alim_p;
  logic signed [31:0] ta_next;

  assign alim_p = $signed({28'd0, alim_sel});
  always_comb begin
    if (prod > alim_p) begin
      ta_next = $signed({1'b0, alim_sel});
    end else if (prod < -alim_p) begin
      ta_next = -$signed({1'b0, alim_sel});
    end else begin
      ta_next = prod[31:0];
    end
  end

  // Round to nearest on the Q0.24 period; products here are never negative.
  logic signed [58:0] rnd_sum;
  assign rnd_sum = prod + 59'sd8388608;

  // Jerk ramp.
  logic [33:0]        diff_mag, step_ext;
  logic               over;
  logic signed [33:0] a_ramp, a_abs;

  assign diff_mag = diff_r[33] ? 34'(-diff_r) : 34'(diff_r);
  assign step_ext = {3'b000, step_r};
  assign over     = diff_mag > step_ext;

  always_comb begin
    if (!over) begin
      a_ramp = ta_ext;
    end else if (diff_r[33]) begin
      a_ramp = ma_ext - $signed(step_ext);
    end else begin
      a_ramp = ma_ext + $signed(step_ext);
    end
  end
  assign a_abs = a_ramp[33] ? -a_ramp : a_ramp;

  // Velocity update.
  logic signed [33:0] rr_s;
  logic signed [34:0] acc_sum;
  logic signed [31:0] acc_sat;

  assign rr_s    = $signed({1'b0, rnd_sum[56:24]});
  assign acc_sum = {{3{mv_sel[31]}}, mv_sel} + {r_s[33], r_s};
  assign acc_sat = sat32(acc_sum);

  // Yaw unwrap.
  logic [19:0]        jump;
  logic signed [20:0] delta;
  logic signed [34:0] yaw_sum;

  assign jump = ydiff[19] ? 20'(-ydiff) : 20'(ydiff);
  always_comb begin
    if (wrap_up && (jump > WRAP_JUMP)) begin
      delta = -{ydiff[19], ydiff} + TWO_PI_Q;
    end else if (wrap_dn && (jump > WRAP_JUMP)) begin
      delta = -{ydiff[19], ydiff} - TWO_PI_Q;
    end else begin
      delta = -{ydiff[19], ydiff};
    end
  end
  assign yaw_sum = {{3{yaw_total[31]}}, yaw_total} + {{14{delta[20]}}, delta};

  logic done;
  assign done = (elapsed >= MOTION_TICKS);

  // Configuration and tick state.
  always_ff @(posedge clk) begin
    if (rst) begin
      tick_period    <= TICK_PERIOD_RESET;
      tick_rate      <= TICK_RATE_RESET;
      lin_vel_limit  <= LIN_VEL_LIMIT_RESET;
      lin_acc_limit  <= LIN_ACC_LIMIT_RESET;
      lin_jerk_limit <= LIN_JERK_LIMIT_RESET;
      ang_vel_limit  <= ANG_VEL_LIMIT_RESET;
      ang_acc_limit  <= ANG_ACC_LIMIT_RESET;
      ang_jerk_limit <= ANG_JERK_LIMIT_RESET;
      yaw_total      <= YAW_TOTAL_RESET;
      yaw_before     <= YAW_BEFORE_RESET;
      elapsed        <= '0;
    end else begin
      if (cfg_write) begin
        case (cfg_addr)
          CFG_TICK_PERIOD:    tick_period    <= cfg_data[23:0];
          CFG_TICK_RATE:      tick_rate      <= cfg_data[15:0];
          CFG_LIN_VEL_LIMIT:  lin_vel_limit  <= cfg_data;
          CFG_LIN_ACC_LIMIT:  lin_acc_limit  <= cfg_data;
          CFG_LIN_JERK_LIMIT: lin_jerk_limit <= cfg_data;
          CFG_ANG_VEL_LIMIT:  ang_vel_limit  <= cfg_data;
          CFG_ANG_ACC_LIMIT:  ang_acc_limit  <= cfg_data;
          CFG_ANG_JERK_LIMIT: ang_jerk_limit <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.op == OP_YAW2) begin
        yaw_total  <= sat32(yaw_sum);
        yaw_before <= meas_yaw;
        if (elapsed != TICKS_MAX) begin
          elapsed <= elapsed + 18'd1;
        end
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        want_vx  <= in_data[31:0];
        want_vy  <= in_data[63:32];
        want_yaw <= in_data[95:64];
        meas_yaw <= in_data[114:96];
        meas_vx  <= in_data[146:115];
        meas_vy  <= in_data[178:147];
        meas_wz  <= in_data[210:179];
        meas_ax  <= in_data[242:211];
        meas_ay  <= in_data[274:243];
        meas_awz <= in_data[306:275];
      end
      OP_YAW1: begin
        ydiff   <= {yaw_before[18], yaw_before} - {meas_yaw[18], meas_yaw};
        wrap_up <= (yaw_before > 19'sd0) && meas_yaw[18];
        wrap_dn <= yaw_before[18] && (meas_yaw > 19'sd0);
      end
      OP_YERR:  want_w <= {want_yaw[31], want_yaw} - {yaw_total[31], yaw_total};
      OP_DIFF:  d_r <= d_next;
      OP_MRATE: prod <= mul_p;
      OP_MSTEP: begin
        ta   <= ta_next;
        prod <= mul_p;
      end
      OP_STEP: begin
        step_r <= rnd_sum[54:24];
        diff_r <= ta_ext - ma_ext;
      end
      OP_RAMP: begin
        a_neg <= a_ramp[33];
        a_mag <= a_abs[32:0];
      end
      OP_MDT:   prod <= mul_p;
      OP_ROUND: r_s <= a_neg ? -rr_s : rr_s;
      OP_ACC: begin
        case (cmd.axis)
          AXIS_X:  res_vx <= acc_sat;
          AXIS_Y:  res_vy <= acc_sat;
          default: res_wz <= acc_sat;
        endcase
      end
      OP_OUT: out_data <= {7'd0, done, yaw_total, res_wz, res_vy, res_vx};
      default: ;
    endcase
  end

endmodule
`default_nettype wire

// ===== bench/tb.sv =====
// Self-checking bench for the jerk-limited velocity shaper core, with its own shaping predictor.
`timescale 1ns / 1ps
module tb;
  import jlvs_pkg::*;

  // Input word as packed on s_tdata (last member in the lowest bits).
  typedef struct packed {
    logic [4:0]         pad;
    logic signed [31:0] meas_awz;
    logic signed [31:0] meas_ay;
    logic signed [31:0] meas_ax;
    logic signed [31:0] meas_wz;
    logic signed [31:0] meas_vy;
    logic signed [31:0] meas_vx;
    logic signed [18:0] meas_yaw;
    logic signed [31:0] want_yaw;
    logic signed [31:0] want_vy;
    logic signed [31:0] want_vx;
  } tick_in_t;

  // Output word as packed on m_tdata.
  typedef struct packed {
    logic [6:0]  pad;
    logic        done;
    logic [31:0] yaw;
    logic [31:0] wz;
    logic [31:0] vy;
    logic [31:0] vx;
  } tick_out_t;

  typedef struct {
    tick_in_t    word;
    int unsigned gap;
  } tick_req_t;

  localparam longint WORD_MAX    = 64'sd2147483647;
  localparam longint WORD_MIN    = -64'sd2147483648;
  localparam longint WRAP_Q      = WRAP_JUMP;
  localparam longint TURN_Q      = TWO_PI_Q;
  localparam int     QUIET_LIMIT = 2000;
  localparam int     SPIN_TURNS  = 20;

  logic              clk;
  logic              rst = 1'b1;
  logic              cfg_write = 1'b0;
  logic [2:0]        cfg_addr = '0;
  logic [30:0]       cfg_data = '0;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [IN_W-1:0]   s_tdata = '0;
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [OUT_W-1:0]  m_tdata;

  jerk_limited_velocity_shaper_core dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_write(cfg_write),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Predictor state and register copies.
  bit [30:0] cfg_reg [8];
  longint    yaw_sum;
  longint    yaw_prev;
  int        tick_count;

  tick_req_t   tick_queue [$];
  tick_out_t   shaped_due [$];
  int          ticks_queued = 0;
  int          ticks_sent = 0;
  int          fail_count = 0;
  int          quiet_cycles = 0;
  bit          idling = 1'b1;
  logic        in_took = 1'b0;
  logic        out_took = 1'b0;
  bit          staged = 1'b0;
  int unsigned gap_left = 0;
  tick_req_t   next_req;
  int unsigned rx_hold = 0;

  // Stimulus generator's view of the yaw trajectory.
  int track_yaw = 205887;
  int track_total = 205887;

  function automatic longint sat_word(longint v);
    if (v > WORD_MAX) return WORD_MAX;
    if (v < WORD_MIN) return WORD_MIN;
    return v;
  endfunction

  function automatic longint limit_mag(longint v, longint lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  // Acceleration times dt at Q16.16, rounded half away from zero.
  function automatic longint scale_dt(longint a, longint per);
    longint m;
    m = (a < 0) ? -a : a;
    m = (m * per + (64'sd1 <<< 23)) >>> 24;
    return (a < 0) ? -m : m;
  endfunction

  function automatic longint shape_axis(longint want_v, longint meas_v, longint meas_a,
                                        bit ang);
    longint vlim, alim, jlim, per, rate, tv, ta, step, diff, a;
    vlim = ang ? cfg_reg[CFG_ANG_VEL_LIMIT] : cfg_reg[CFG_LIN_VEL_LIMIT];
    alim = ang ? cfg_reg[CFG_ANG_ACC_LIMIT] : cfg_reg[CFG_LIN_ACC_LIMIT];
    jlim = ang ? cfg_reg[CFG_ANG_JERK_LIMIT] : cfg_reg[CFG_LIN_JERK_LIMIT];
    per = cfg_reg[CFG_TICK_PERIOD];
    rate = cfg_reg[CFG_TICK_RATE];
    tv = limit_mag(want_v, vlim);
    ta = limit_mag((tv - meas_v) * rate, alim);
    step = (jlim * per + (64'sd1 <<< 23)) >>> 24;
    diff = ta - meas_a;
    a = ta;
    if (((diff < 0) ? -diff : diff) > step)
      a = (diff > 0) ? meas_a + step : meas_a - step;
    return sat_word(meas_v + scale_dt(a, per));
  endfunction

  task automatic shape_tick(input tick_in_t w, output tick_out_t r);
    longint cur, pre, jump, delta, vx, vy, wz;
    cur = w.meas_yaw;
    pre = yaw_prev;
    jump = (pre > cur) ? pre - cur : cur - pre;
    // A large jump across the sign boundary is a wrap through pi.
    if (pre > 0 && cur < 0 && jump > WRAP_Q)
      delta = cur + TURN_Q - pre;
    else if (pre < 0 && cur > 0 && jump > WRAP_Q)
      delta = cur - TURN_Q - pre;
    else
      delta = cur - pre;
    yaw_sum = sat_word(yaw_sum + delta);
    yaw_prev = cur;
    vx = shape_axis(w.want_vx, w.meas_vx, w.meas_ax, 1'b0);
    vy = shape_axis(w.want_vy, w.meas_vy, w.meas_ay, 1'b0);
    wz = shape_axis(longint'(w.want_yaw) - yaw_sum, w.meas_wz, w.meas_awz, 1'b1);
    if (tick_count < TICKS_MAX)
      tick_count++;
    r = '0;
    r.vx = vx[31:0];
    r.vy = vy[31:0];
    r.wz = wz[31:0];
    r.yaw = yaw_sum[31:0];
    r.done = (tick_count >= MOTION_TICKS);
  endtask

  task automatic check_field(string what, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s expected %h got %h", $time, what, exp_v, act_v);
      fail_count++;
    end
  endtask

  // Driver: presents queued words after their drawn gap, changing at the falling edge.
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || in_took) begin
      if (!staged && tick_queue.size() != 0) begin
        next_req = tick_queue.pop_front();
        staged = 1'b1;
        gap_left = next_req.gap;
      end
      if (staged && gap_left == 0) begin
        s_tvalid <= 1'b1;
        s_tdata <= next_req.word;
        staged = 1'b0;
      end else begin
        s_tvalid <= 1'b0;
        if (staged)
          gap_left--;
      end
    end
  end

  // Receiver back-pressure: while idling is set, a fresh stall is drawn after every word taken.
  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (out_took)
        rx_hold = idling ? $urandom_range(0, 19) : 0;
      if (rx_hold > 0) begin
        m_tready <= 1'b0;
        rx_hold--;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Monitor: predicts on input handshakes, checks output words, and keeps the watchdog.
  always @(posedge clk) begin : monitor
    tick_out_t seen, due;
    in_took <= s_tvalid && s_tready && !rst;
    out_took <= m_tvalid && m_tready && !rst;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        shape_tick(tick_in_t'(s_tdata), due);
        shaped_due.push_back(due);
        ticks_sent++;
      end
      if (m_tvalid && m_tready) begin
        seen = m_tdata;
        if (shaped_due.size() == 0) begin
          $display("%0t: unexpected word, expected none got %h", $time, m_tdata);
          fail_count++;
        end else begin
          due = shaped_due.pop_front();
          check_field("out_vx", due.vx, seen.vx);
          check_field("out_vy", due.vy, seen.vy);
          check_field("out_wz", due.wz, seen.wz);
          check_field("unwrapped_yaw", due.yaw, seen.yaw);
          check_field("motion_done", due.done, seen.done);
        end
      end
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
          $display("Some tests failed");
          $finish;
        end
      end
    end
  end

  function automatic logic [31:0] corner_word(int k);
    case (k % 5)
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'h0000_0000;
      3: return 32'hFFFF_FFFF;
      default: return 32'h0000_0001;
    endcase
  endfunction

  // Mostly modest Q16.16 magnitudes so clamps and the jerk ramp both engage and release.
  function automatic logic [31:0] pick_word();
    logic [31:0] v;
    int unsigned sh;
    sh = $urandom_range(4, 22);
    case ($urandom_range(0, 7))
      0: return $urandom;
      1: return corner_word($urandom_range(0, 4));
      default: begin
        v = $urandom & ((32'd1 << sh) - 1);
        return $urandom_range(0, 1) ? -v : v;
      end
    endcase
  endfunction

  function automatic logic [30:0] pick_limit(int bits);
    int unsigned n;
    n = $urandom_range(0, bits);
    return 31'($urandom & ((32'd1 << n) - 1));
  endfunction

  function automatic tick_in_t make_tick();
    tick_in_t w;
    int step;
    w = '0;
    w.want_vx = pick_word();
    w.want_vy = pick_word();
    w.want_yaw = $urandom;
    w.meas_vx = pick_word();
    w.meas_vy = pick_word();
    w.meas_wz = pick_word();
    w.meas_ax = pick_word();
    w.meas_ay = pick_word();
    w.meas_awz = pick_word();
    if ($urandom_range(0, 9) == 0) begin
      w.meas_yaw = 19'($urandom);
    end else begin
      // A plausible heading trace that crosses pi now and then.
      step = $urandom_range(0, 52428) - 26214;
      track_yaw += step;
      track_total += step;
      if (track_yaw > 205887)
        track_yaw -= 411775;
      else if (track_yaw < -205887)
        track_yaw += 411775;
      w.meas_yaw = 19'(track_yaw);
      if ($urandom_range(0, 3) != 0)
        w.want_yaw = track_total + int'($urandom_range(0, 262144)) - 131072;
    end
    return w;
  endfunction

  task automatic queue_tick(tick_in_t w);
    tick_req_t req;
    req.word = w;
    req.gap = idling ? $urandom_range(0, 19) : 0;
    tick_queue.push_back(req);
    ticks_queued++;
  endtask

  task automatic drain();
    do @(negedge clk);
    while (ticks_sent != ticks_queued || shaped_due.size() != 0);
    repeat (40) @(negedge clk);
  endtask

  task automatic run_random(int n);
    repeat (n) queue_tick(make_tick());
    drain();
  endtask

  task automatic write_reg(logic [2:0] idx, logic [30:0] val);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= val;
    if (idx == CFG_TICK_PERIOD)
      cfg_reg[idx] = {7'd0, val[23:0]};
    else if (idx == CFG_TICK_RATE)
      cfg_reg[idx] = {15'd0, val[15:0]};
    else
      cfg_reg[idx] = val;
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic load_limits(logic [30:0] per, logic [30:0] rate, logic [30:0] lv,
                             logic [30:0] la, logic [30:0] lj, logic [30:0] av,
                             logic [30:0] aa, logic [30:0] aj);
    write_reg(CFG_TICK_PERIOD, per);
    write_reg(CFG_TICK_RATE, rate);
    write_reg(CFG_LIN_VEL_LIMIT, lv);
    write_reg(CFG_LIN_ACC_LIMIT, la);
    write_reg(CFG_LIN_JERK_LIMIT, lj);
    write_reg(CFG_ANG_VEL_LIMIT, av);
    write_reg(CFG_ANG_ACC_LIMIT, aa);
    write_reg(CFG_ANG_JERK_LIMIT, aj);
  endtask

  initial begin
    tick_in_t w;
    int yaw_seq [12];
    cfg_reg[CFG_TICK_PERIOD] = TICK_PERIOD_RESET;
    cfg_reg[CFG_TICK_RATE] = TICK_RATE_RESET;
    cfg_reg[CFG_LIN_VEL_LIMIT] = LIN_VEL_LIMIT_RESET;
    cfg_reg[CFG_LIN_ACC_LIMIT] = LIN_ACC_LIMIT_RESET;
    cfg_reg[CFG_LIN_JERK_LIMIT] = LIN_JERK_LIMIT_RESET;
    cfg_reg[CFG_ANG_VEL_LIMIT] = ANG_VEL_LIMIT_RESET;
    cfg_reg[CFG_ANG_ACC_LIMIT] = ANG_ACC_LIMIT_RESET;
    cfg_reg[CFG_ANG_JERK_LIMIT] = ANG_JERK_LIMIT_RESET;
    yaw_sum = YAW_TOTAL_RESET;
    yaw_prev = YAW_BEFORE_RESET;
    tick_count = 0;
    repeat (2) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    // Wraps both ways, jumps just at and just past 3 rad, and headings beyond pi.
    yaw_seq = '{205887, -205887, 205887, 98304, -98304, 98305,
                -98304, 0, 262143, -262144, 196608, -1};
    for (int i = 0; i < 12; i++) begin
      w = '0;
      w.want_vx = corner_word(i);
      w.want_vy = corner_word(i + 1);
      w.want_yaw = corner_word(i + 2);
      w.meas_yaw = yaw_seq[i][18:0];
      w.meas_vx = corner_word(i + 3);
      w.meas_vy = corner_word(i + 4);
      w.meas_wz = corner_word(i + 5);
      w.meas_ax = corner_word(i + 6);
      w.meas_ay = corner_word(i + 7);
      w.meas_awz = corner_word(i + 8);
      queue_tick(w);
    end
    drain();
    run_random(200);

    // Every register at its top value; the upper data bits are dropped for the narrow ones.
    load_limits('1, '1, '1, '1, '1, '1, '1, '1);
    run_random(150);

    // Zero period and rate: each command falls back to its measured velocity.
    load_limits('0, '0, '0, '0, '0, '0, '0, '0);
    run_random(100);

    for (int p = 0; p < 4; p++) begin
      idling = (p != 2);
      load_limits({7'($urandom), 24'(pick_limit(24))}, {15'($urandom), 16'(pick_limit(16))},
                  pick_limit(31), pick_limit(31), pick_limit(31),
                  pick_limit(31), pick_limit(31), pick_limit(31));
      run_random(150);
    end
    idling = 1'b1;

    load_limits(TICK_PERIOD_RESET, TICK_RATE_RESET, LIN_VEL_LIMIT_RESET, LIN_ACC_LIMIT_RESET,
                LIN_JERK_LIMIT_RESET, ANG_VEL_LIMIT_RESET, ANG_ACC_LIMIT_RESET,
                ANG_JERK_LIMIT_RESET);
    run_random(150);

    // Spin the heading one way, a full turn every three words, so that the
    // accumulated yaw climbs steadily through repeated wraps.
    idling = 1'b0;
    yaw_seq[0] = 262143;
    yaw_seq[1] = -1;
    yaw_seq[2] = 196607;
    for (int k = 0; k < 3 * SPIN_TURNS; k++) begin
      w = make_tick();
      w.meas_yaw = yaw_seq[k % 3][18:0];
      queue_tick(w);
    end
    drain();

    if (fail_count == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
